FILE: src/wbsc_pkg.sv
// package: shared types, command codes and helpers for the weighted basis sum block
`timescale 1ns / 1ps

package wbsc_pkg;

    // command codes carried by an input item
    localparam logic [1:0] CMD_ACC       = 2'd0;
    localparam logic [1:0] CMD_WR_WEIGHT = 2'd1;
    localparam logic [1:0] CMD_ADD_DELTA = 2'd2;
    localparam logic [1:0] CMD_WR_BOUND  = 2'd3;

    // bound select codes
    localparam logic BSEL_LOWER = 1'b0;
    localparam logic BSEL_UPPER = 1'b1;

    // q16.16 rounding constant and 32/64 bit limits
    localparam logic signed [63:0] RND_HALF = 64'sd32768;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] S32_MAX  = 32'sh7fff_ffff;
    localparam logic signed [63:0] S64_MIN  = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] S64_MAX  = 64'sh7fff_ffff_ffff_ffff;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW_RD,
        S_RMW_WR,
        S_MAC,
        S_OUT
    } t_state;

    // control travelling alongside a weight through the multiply pipe
    typedef struct packed {
        logic vld;
        logic fin;
    } t_mac_ctl;

    // saturate a 33 bit signed sum to 32 bits
    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v[32] != v[31]) begin
                r = v[32] ? S32_MIN : S32_MAX;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

endpackage

FILE: src/weighted_basis_sum_clamp_core.sv
// top level: sequencer, weight memory, bounds, accumulators and output register
`timescale 1ns / 1ps

// Weighted basis sum with per-axis clamp. Items are taken one at a time; the
// input stalls while an item is being worked on. A weight write or bound
// write is done in the idle state as the item is accepted. A weight delta
// add steps through accept, read of the weight memory and saturating write
// back. An accumulate reads one weight column entry per axis from the weight
// memory each cycle and feeds it through the registered memory read and the
// product register of the one shared multiplier and accumulate unit. An
// accumulate marked last then emits AXES results in axis order, one per
// cycle when the output is not stalled; a result register decouples the
// output so the next item may be accepted while the final result is still
// waiting. After reset the weight memory is zeroed by a clearing pass over
// all AXES*MAX_BASES entries, during which no item is accepted; the clamp
// enable register can be written at any time and resets to 1.

module weighted_basis_sum_clamp_core
    import wbsc_pkg::*;
#(
    parameter int MAX_BASES = 16,
    parameter int AXES      = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_basis_index,
    input  logic [2:0]         i_axis,
    input  logic               i_bound_select,
    input  logic signed [31:0] i_value,
    input  logic               i_last,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_out_axis,
    output logic signed [31:0] o_action,
    output logic               o_last_of_run
);

    localparam int DEPTH = AXES * MAX_BASES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int IW    = $clog2(AXES + 1);

    // state and item registers
    t_state             r_state;
    t_state             n_state;
    logic               r_clamp_en;
    logic [AW-1:0]      r_clr;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_waddr;
    logic signed [31:0] r_val;
    logic               r_last;
    logic [IW-1:0]      r_iss;
    t_mac_ctl           r_rd_ctl;
    logic [XW-1:0]      r_acc_ax;
    logic [XW-1:0]      r_out_ax;
    logic signed [63:0] r_acc [AXES];
    logic signed [31:0] r_lo  [AXES];
    logic signed [31:0] r_hi  [AXES];
    logic               r_o_vld;
    logic [2:0]         r_o_ax;
    logic signed [31:0] r_o_act;
    logic               r_o_last;

    // decode and control
    logic               w_accept;
    logic               w_col_ok;
    logic               w_ax_ok;
    logic [AW-1:0]      w_wt_addr;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic [AW-1:0]      w_raddr;
    logic [31:0]        w_rdata;
    logic               w_issue;
    t_mac_ctl           w_iss_ctl;
    t_mac_ctl           w_mac_ctl;
    logic signed [63:0] w_mac_sum;
    logic               w_load;
    logic [XW-1:0]      w_acc_idx;
    logic signed [63:0] w_acc_rd;
    logic signed [31:0] w_clamped;

    assign w_accept  = i_valid && !o_stall;
    assign w_col_ok  = (32'(i_basis_index) < 32'(MAX_BASES));
    assign w_ax_ok   = (32'(i_axis) < 32'(AXES));
    assign w_wt_addr = AW'(32'(i_axis) * 32'(MAX_BASES) + 32'(i_basis_index));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_ADD_DELTA: begin
                            if (w_col_ok && w_ax_ok) begin
                                n_state = S_RMW_RD;
                            end
                        end
                        CMD_ACC: begin
                            if (w_col_ok) begin
                                n_state = S_MAC;
                            end else if (i_last) begin
                                n_state = S_OUT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_RMW_RD: n_state = S_RMW_WR;
            S_RMW_WR: n_state = S_IDLE;
            S_MAC: begin
                if (w_mac_ctl.vld && w_mac_ctl.fin) begin
                    n_state = r_last ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                if (w_load && (r_out_ax == XW'(AXES - 1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall   = 1'b1;
        w_we      = 1'b0;
        w_waddr   = w_wt_addr;
        w_wdata   = i_value;
        w_raddr   = r_waddr;
        w_issue   = 1'b0;
        w_load    = 1'b0;
        w_acc_idx = r_acc_ax;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
            end
            S_IDLE: begin
                o_stall = 1'b0;
                w_we    = i_valid && (i_cmd == CMD_WR_WEIGHT) && w_col_ok && w_ax_ok;
            end
            S_RMW_WR: begin
                w_we    = 1'b1;
                w_waddr = r_waddr;
                w_wdata = f_sat32(33'(signed'(w_rdata)) + 33'(r_val));
            end
            S_MAC: begin
                w_raddr = r_addr;
                w_issue = (r_iss != IW'(AXES));
            end
            S_OUT: begin
                w_load    = !r_o_vld || !i_stall;
                w_acc_idx = r_out_ax;
            end
            default: o_stall = 1'b1;
        endcase
    end

    assign w_iss_ctl.vld = w_issue;
    assign w_iss_ctl.fin = (r_iss == IW'(AXES - 1));
    assign w_acc_rd      = r_acc[w_acc_idx];

    // weight memory
    wbsc_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_wt_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // shared multiply-accumulate unit
    wbsc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (r_val),
        .i_b     (signed'(w_rdata)),
        .i_acc   (w_acc_rd),
        .o_ctl   (w_mac_ctl),
        .o_sum   (w_mac_sum)
    );

    // clamp and saturate the axis being emitted
    wbsc_clamp u_clamp (
        .i_en  (r_clamp_en),
        .i_sum (w_acc_rd),
        .i_lo  (r_lo[r_out_ax]),
        .i_hi  (r_hi[r_out_ax]),
        .o_res (w_clamped)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clamp_en <= 1'b1;
            r_clr      <= '0;
            r_iss      <= '0;
            r_rd_ctl   <= '0;
            r_acc_ax   <= '0;
            r_out_ax   <= '0;
            r_o_vld    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_ctl <= w_iss_ctl;
            if (i_cfg_we) begin
                r_clamp_en <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (w_accept) begin
                r_iss    <= '0;
                r_acc_ax <= '0;
                r_out_ax <= '0;
            end
            if (w_issue) begin
                r_iss <= r_iss + IW'(1);
            end
            if (w_mac_ctl.vld) begin
                r_acc_ax <= r_acc_ax + XW'(1);
            end
            if (w_load) begin
                r_out_ax <= r_out_ax + XW'(1);
                r_o_vld  <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // item payload and weight read address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_val   <= i_value;
            r_last  <= i_last;
            r_waddr <= w_wt_addr;
            r_addr  <= AW'(i_basis_index);
        end else if (w_issue) begin
            r_addr <= AW'(32'(r_addr) + 32'(MAX_BASES));
        end
    end

    // accumulators: written by the multiply unit, cleared as each result leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_acc[i] <= '0;
            end
        end else if (w_mac_ctl.vld) begin
            r_acc[w_acc_idx] <= w_mac_sum;
        end else if (w_load) begin
            r_acc[w_acc_idx] <= '0;
        end
    end

    // bound registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_lo[i] <= S32_MIN;
                r_hi[i] <= S32_MAX;
            end
        end else if (w_accept && (i_cmd == CMD_WR_BOUND) && w_ax_ok) begin
            if (i_bound_select == BSEL_UPPER) begin
                r_hi[XW'(i_axis)] <= i_value;
            end else begin
                r_lo[XW'(i_axis)] <= i_value;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_ax   <= 3'(r_out_ax);
            r_o_act  <= w_clamped;
            r_o_last <= (r_out_ax == XW'(AXES - 1));
        end
    end

    assign o_valid       = r_o_vld;
    assign o_out_axis    = r_o_ax;
    assign o_action      = r_o_act;
    assign o_last_of_run = r_o_last;

`ifndef SYNTHESIS
    // accumulator updates only come from a running accumulate
    a_mac_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_ctl.vld |-> (r_state == S_MAC))
        else $error("accumulator update outside accumulate");

    // a new result only follows an output step
    a_load_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == S_OUT))
        else $error("result appeared outside output step");

    // the weight memory is never written while a column is being read
    a_no_write_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> !w_we)
        else $error("weight write during accumulate");

    // accumulators are idle while results are emitted
    a_no_mac_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> !w_mac_ctl.vld && !r_rd_ctl.vld)
        else $error("multiply pipe busy during output");
`endif

endmodule

FILE: src/wbsc_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module wbsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/wbsc_mac.sv
// shared multiply, round and saturating accumulate unit
`timescale 1ns / 1ps

module wbsc_mac
    import wbsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctl           i_ctl,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    input  logic signed [63:0] i_acc,
    output t_mac_ctl           o_ctl,
    output logic signed [63:0] o_sum
);

    logic signed [63:0] r_prod;
    t_mac_ctl           r_ctl;
    logic signed [63:0] w_term;
    logic signed [63:0] w_raw;
    logic               w_ovf;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    // round half up to q16.16, then add with 64 bit saturation
    always_comb begin
        w_term = (r_prod + RND_HALF) >>> 16;
        w_raw  = i_acc + w_term;
        w_ovf  = (i_acc[63] == w_term[63]) && (w_raw[63] != i_acc[63]);
        if (w_ovf) begin
            o_sum = i_acc[63] ? S64_MIN : S64_MAX;
        end else begin
            o_sum = w_raw;
        end
    end

    assign o_ctl = r_ctl;

endmodule

FILE: src/wbsc_clamp.sv
// per-axis clamp to bounds and saturation of a 64 bit sum to 32 bits
`timescale 1ns / 1ps

module wbsc_clamp
    import wbsc_pkg::*;
(
    input  logic               i_en,
    input  logic signed [63:0] i_sum,
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    output logic signed [31:0] o_res
);

    logic signed [63:0] w_lo;
    logic signed [63:0] w_hi;
    logic signed [63:0] w_s;

    // when the bounds cross, the lower bound wins for a sum below it, else the upper
    always_comb begin
        w_lo = {{32{i_lo[31]}}, i_lo};
        w_hi = {{32{i_hi[31]}}, i_hi};
        w_s  = i_sum;
        if (i_en) begin
            if (w_lo > i_sum) begin
                w_s = w_lo;
            end else if (w_hi < i_sum) begin
                w_s = w_hi;
            end
        end
        // limits are compared as signed 64 bit values
        if (w_s > signed'({{32{1'b0}}, S32_MAX})) begin
            o_res = S32_MAX;
        end else if (w_s < signed'({{32{1'b1}}, S32_MIN})) begin
            o_res = S32_MIN;
        end else begin
            o_res = w_s[31:0];
        end
    end

endmodule
